### sv/utc_to_tai_day_msec_defines.svh
// assertion macros used by the checker file utd_port_checker
`ifndef UTC_TO_TAI_DAY_MSEC_DEFINES_SVH
`define UTC_TO_TAI_DAY_MSEC_DEFINES_SVH

// same-cycle implication, quiet while reset is asserted
`define UTD_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("utd assertion failed");

// next-cycle implication, quiet while reset is asserted
`define UTD_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("utd assertion failed");

`endif

### sv/utd_pkg.sv
package utd_pkg;

	localparam int KNOWN_LEAPS = 23;
	localparam int LIDX_W      = $clog2(KNOWN_LEAPS);
	localparam int CFG_W       = 14;
	localparam int CFG_IDX_W   = 3;

	localparam logic STATUS_OK  = 1'b0;
	localparam logic STATUS_BAD = 1'b1;

	localparam logic [CFG_IDX_W-1:0] REG_FIRST_YEAR  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FIRST_MONTH = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_END_YEAR    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_END_MONTH   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_EPOCH_DAYS  = 3'd4;

	// year and month packed as one sortable key
	typedef logic [15:0] ym_key_t;

	localparam ym_key_t LEAP_KEY [KNOWN_LEAPS] = '{
		{12'd1972, 4'd0}, {12'd1972, 4'd6}, {12'd1973, 4'd0}, {12'd1974, 4'd0},
		{12'd1975, 4'd0}, {12'd1976, 4'd0}, {12'd1977, 4'd0}, {12'd1978, 4'd0},
		{12'd1979, 4'd0}, {12'd1980, 4'd0}, {12'd1981, 4'd6}, {12'd1982, 4'd6},
		{12'd1983, 4'd6}, {12'd1985, 4'd6}, {12'd1988, 4'd0}, {12'd1990, 4'd0},
		{12'd1991, 4'd0}, {12'd1992, 4'd6}, {12'd1993, 4'd6}, {12'd1994, 4'd6},
		{12'd1996, 4'd0}, {12'd1997, 4'd6}, {12'd1999, 4'd0}
	};

	localparam logic [5:0] LEAP_DELTA [KNOWN_LEAPS] = '{
		6'd10, 6'd11, 6'd12, 6'd13, 6'd14, 6'd15, 6'd16, 6'd17,
		6'd18, 6'd19, 6'd20, 6'd21, 6'd22, 6'd23, 6'd24, 6'd25,
		6'd26, 6'd27, 6'd28, 6'd29, 6'd30, 6'd31, 6'd32
	};

	typedef struct packed {
		logic [11:0] first_year;
		logic [3:0]  first_month;
		logic [11:0] end_year;
		logic [3:0]  end_month;
		logic [13:0] epoch_day_offset;
	} cfg_t;

	typedef struct packed {
		logic        ok;
		logic [15:0] day_number;
		logic [16:0] sec_of_day;
		logic [19:0] usec;
		logic [9:0]  usec_ms;
		logic [5:0]  delta;
	} calc_t;

	function automatic logic [4:0] month_len(input logic [3:0] m);
		if (m == 4'd1) begin
			return 5'd28;
		end else if (m inside {4'd3, 4'd5, 4'd8, 4'd10}) begin
			return 5'd30;
		end else begin
			return 5'd31;
		end
	endfunction

	function automatic logic [8:0] month_start(input logic [3:0] m);
		case (m)
			4'd0:    return 9'd0;
			4'd1:    return 9'd31;
			4'd2:    return 9'd59;
			4'd3:    return 9'd90;
			4'd4:    return 9'd120;
			4'd5:    return 9'd151;
			4'd6:    return 9'd181;
			4'd7:    return 9'd212;
			4'd8:    return 9'd243;
			4'd9:    return 9'd273;
			4'd10:   return 9'd304;
			4'd11:   return 9'd334;
			default: return 9'd0;
		endcase
	endfunction

	// key of the month just before the given one
	function automatic ym_key_t prev_key(input ym_key_t k);
		if (k[3:0] == 4'd0) begin
			return {k[15:4] - 12'd1, 4'd11};
		end else begin
			return {k[15:4], k[3:0] - 4'd1};
		end
	endfunction

	function automatic ym_key_t leap_key_at(input logic [LIDX_W-1:0] i);
		if (int'(i) < KNOWN_LEAPS) begin
			return LEAP_KEY[i];
		end else begin
			return '1;
		end
	endfunction

	function automatic logic [5:0] leap_delta_at(input logic [LIDX_W-1:0] i);
		if (int'(i) < KNOWN_LEAPS) begin
			return LEAP_DELTA[i];
		end else begin
			return '0;
		end
	endfunction

endpackage

### sv/utc_to_tai_day_msec.sv
// UTC to TAI converter. Each input transaction carries a broken-down UTC time
// (year, month and day counted from zero, hour, minute, second, microsecond);
// each accepted transaction yields exactly one output transaction. Every field
// is range checked: the (year, month) pair must lie in the configured window
// [first_year/first_month, end_year/end_month), the day must fit the month
// with gregorian leap years, and a second of 60 is allowed only at 23:59 on
// the last day of a month that directly precedes a leap-second table entry.
// On any failure status is 1 and all other output fields are zero. Otherwise
// the block returns days since the epoch (epoch_day_offset days before
// 1972-01-01, wrapping at 2^16), milliseconds of the day, the microsecond
// remainder, and TAI as whole seconds (wrapping at 2^33) plus microseconds.
// Throughput is one transaction per clock when not stalled. Data passes an
// input register, one compute register and the output register, with table
// compares and day count between the first two and the tai seconds and
// millisecond products between the last two. Stalls back up through the three
// registers, so in_stall rises only when all of them hold data and out_stall
// is high. LEAP_ENTRIES-1 table entries are used, capped at the 23 built-in
// ones; the last one used opens an interval with no following leap minute.
// Configuration registers are written through cfg_write/cfg_index/cfg_data by
// index; indexes past the last one are ignored. The user must write them only
// while no transaction is in flight, which the block does not enforce.
module utc_to_tai_day_msec import utd_pkg::*; #(
	parameter int LEAP_ENTRIES = 24
) (
	input  logic                 clk,
	input  logic                 arst_n,

	input  logic                 cfg_write,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data,

	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic [11:0]          year_in,
	input  logic [3:0]           month_index,
	input  logic [4:0]           day_index,
	input  logic [4:0]           hour_in,
	input  logic [5:0]           minute_in,
	input  logic [5:0]           second_in,
	input  logic [19:0]          microsecond_in,

	output logic                 out_valid,
	input  logic                 out_stall,
	output logic                 status,
	output logic [15:0]          day_number,
	output logic [26:0]          millisecond_of_day,
	output logic [9:0]           microsecond_rest,
	output logic [32:0]          tai_seconds,
	output logic [19:0]          tai_microsecond
);

	// number of table entries in use
	localparam int LEAP_USED = (LEAP_ENTRIES - 1 < KNOWN_LEAPS) ? LEAP_ENTRIES - 1 : KNOWN_LEAPS;

	cfg_t  cfg_q;

	// input register
	logic        valid_s1;
	logic [11:0] year_s1;
	logic [3:0]  month_s1;
	logic [4:0]  day_s1;
	logic [4:0]  hour_s1;
	logic [5:0]  minute_s1;
	logic [5:0]  second_s1;
	logic [19:0] usec_s1;

	// compute register
	logic        valid_s2;
	calc_t       calc_s2;
	calc_t       calc_d;

	// output register
	logic        out_valid_q;
	logic        status_q;
	logic [15:0] day_number_q;
	logic [26:0] msec_q;
	logic [9:0]  usec_rest_q;
	logic [32:0] tai_sec_q;
	logic [19:0] tai_usec_q;

	// stage enables: a slot loads when empty or when its content moves on
	logic en_out, en_s2, en_s1;

	// second-stage results
	logic [26:0] msec_d;
	logic [9:0]  usec_rest_d;
	logic [32:0] tai_sec_d;

	assign en_out   = !out_valid_q || !out_stall;
	assign en_s2    = !valid_s2 || en_out;
	assign en_s1    = !valid_s1 || en_s2;
	assign in_stall = !en_s1;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.first_year       <= 12'd1972;
			cfg_q.first_month      <= 4'd0;
			cfg_q.end_year         <= 12'd2020;
			cfg_q.end_month        <= 4'd0;
			cfg_q.epoch_day_offset <= 14'd5113;
		end else if (cfg_write) begin
			case (cfg_index)
				REG_FIRST_YEAR:  cfg_q.first_year       <= cfg_data[11:0];
				REG_FIRST_MONTH: cfg_q.first_month      <= cfg_data[3:0];
				REG_END_YEAR:    cfg_q.end_year         <= cfg_data[11:0];
				REG_END_MONTH:   cfg_q.end_month        <= cfg_data[3:0];
				REG_EPOCH_DAYS:  cfg_q.epoch_day_offset <= cfg_data[13:0];
				default: ;
			endcase
		end
	end

	// valid bits of the three registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (en_s1) begin
				valid_s1 <= in_valid;
			end
			if (en_s2) begin
				valid_s2 <= valid_s1;
			end
			if (en_out) begin
				out_valid_q <= valid_s2;
			end
		end
	end

	// capture the input transaction
	always_ff @(posedge clk) begin
		if (en_s1 && in_valid) begin
			year_s1   <= year_in;
			month_s1  <= month_index;
			day_s1    <= day_index;
			hour_s1   <= hour_in;
			minute_s1 <= minute_in;
			second_s1 <= second_in;
			usec_s1   <= microsecond_in;
		end
	end

	// checks, table lookup, day count, seconds of day
	utd_day_calc #(
		.LEAP_USED (LEAP_USED)
	) u_day_calc (
		.cfg    (cfg_q),
		.year   (year_s1),
		.month  (month_s1),
		.day    (day_s1),
		.hour   (hour_s1),
		.minute (minute_s1),
		.second (second_s1),
		.usec   (usec_s1),
		.calc   (calc_d)
	);

	always_ff @(posedge clk) begin
		if (en_s2 && valid_s1) begin
			calc_s2 <= calc_d;
		end
	end

	// milliseconds of day, microsecond remainder, tai seconds
	assign msec_d      = 27'(calc_s2.sec_of_day) * 27'd1000 + 27'(calc_s2.usec_ms);
	assign usec_rest_d = 10'(calc_s2.usec - 20'(calc_s2.usec_ms) * 20'd1000);
	assign tai_sec_d   = 33'(calc_s2.day_number) * 33'd86400 +
		33'(calc_s2.sec_of_day) + 33'(calc_s2.delta);

	// result register, status set and all other fields zeroed on a rejected time
	always_ff @(posedge clk) begin
		if (en_out && valid_s2) begin
			status_q     <= calc_s2.ok ? STATUS_OK : STATUS_BAD;
			day_number_q <= calc_s2.ok ? calc_s2.day_number : '0;
			msec_q       <= calc_s2.ok ? msec_d : '0;
			usec_rest_q  <= calc_s2.ok ? usec_rest_d : '0;
			tai_sec_q    <= calc_s2.ok ? tai_sec_d : '0;
			tai_usec_q   <= calc_s2.ok ? calc_s2.usec : '0;
		end
	end

	assign out_valid          = out_valid_q;
	assign status             = status_q;
	assign day_number         = day_number_q;
	assign millisecond_of_day = msec_q;
	assign microsecond_rest   = usec_rest_q;
	assign tai_seconds        = tai_sec_q;
	assign tai_microsecond    = tai_usec_q;

endmodule

### sv/utd_day_calc.sv
module utd_day_calc import utd_pkg::*; #(
	parameter int LEAP_USED = 23
) (
	input  cfg_t        cfg,
	input  logic [11:0] year,
	input  logic [3:0]  month,
	input  logic [4:0]  day,
	input  logic [4:0]  hour,
	input  logic [5:0]  minute,
	input  logic [5:0]  second,
	input  logic [19:0] usec,
	output calc_t       calc
);

	ym_key_t           key;
	logic              month_ok, window_ok, day_ok, time_ok, sec_ok;
	logic [15:0]       y100_t;
	logic [5:0]        y100;
	logic [12:0]       y100_x100;
	logic              leap_year;
	logic [4:0]        mlen;
	logic [LIDX_W-1:0] idx, nxt;
	logic              found;
	logic              leap_minute;
	logic [6:0]        nsec;
	logic [11:0]       yd, p;
	logic [15:0]       p100_t;
	logic [13:0]       p400_t;
	logic [10:0]       leaps_before;
	logic [20:0]       year_days, days_sum;
	logic [8:0]        month_days;
	logic [16:0]       secs;
	logic [42:0]       us_prod;

	assign key       = {year, month};
	assign month_ok  = month < 4'd12;
	assign window_ok = (key >= {cfg.first_year, cfg.first_month}) &&
		(key < {cfg.end_year, cfg.end_month});

	// gregorian leap year: y/100 by reciprocal, exact for 12-bit years
	assign y100_t    = 16'(year[11:2]) * 16'd41;
	assign y100      = y100_t[15:10];
	assign y100_x100 = 13'(y100) * 13'd100;
	assign leap_year = (year[1:0] == 2'd0) &&
		(({1'b0, year} != y100_x100) || (y100[1:0] == 2'd0));

	assign mlen    = month_len(month) + 5'((leap_year && month == 4'd1) ? 1 : 0);
	assign day_ok  = day < mlen;
	assign time_ok = (hour < 5'd24) && (minute < 6'd60) && (usec < 20'd1000000);

	// latest table entry at or before this month
	always_comb begin
		idx   = '0;
		found = 1'b0;
		for (int i = 0; i < LEAP_USED; i++) begin
			if (key >= LEAP_KEY[i]) begin
				idx   = LIDX_W'(i);
				found = 1'b1;
			end
		end
	end

	assign nxt = idx + 1'b1;
	assign leap_minute = (int'(nxt) < LEAP_USED) && (day == mlen - 5'd1) &&
		(hour == 5'd23) && (minute == 6'd59) && (key == prev_key(leap_key_at(nxt)));
	assign nsec   = 7'd60 + (leap_minute ? 7'(leap_delta_at(nxt) - LEAP_DELTA[idx]) : 7'd0);
	assign sec_ok = {1'b0, second} < nsec;

	// days from 1972-01-01 to the start of the year
	assign yd     = year - 12'd1972;
	assign p      = year - 12'd1;
	assign p100_t = 16'(p[11:2]) * 16'd41;
	assign p400_t = 14'(p[11:4]) * 14'd41;
	assign leaps_before = 11'(p[11:2]) - 11'(p100_t[15:10]) + 11'(p400_t[13:10]);
	assign year_days = (year > 12'd1972) ?
		(21'(yd) * 21'd365 + 21'(leaps_before) - 21'd477) : 21'd0;
	assign month_days = month_start(month) + 9'((leap_year && month >= 4'd2) ? 1 : 0);
	assign days_sum = 21'(cfg.epoch_day_offset) + year_days + 21'(month_days) + 21'(day);

	assign secs    = 17'(hour) * 17'd3600 + 17'(minute) * 17'd60 + 17'(second);
	// usec / 1000 by reciprocal, exact below one million
	assign us_prod = 43'(usec) * 43'd4294968;

	assign calc.ok         = month_ok && window_ok && day_ok && time_ok && found && sec_ok;
	assign calc.day_number = days_sum[15:0];
	assign calc.sec_of_day = secs;
	assign calc.usec       = usec;
	assign calc.usec_ms    = us_prod[41:32];
	assign calc.delta      = LEAP_DELTA[idx];

endmodule

### sv/utd_port_checker.sv
`include "utc_to_tai_day_msec_defines.svh"

module utd_port_checker import utd_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_stall,
	input logic        status,
	input logic [15:0] day_number,
	input logic [26:0] millisecond_of_day,
	input logic [9:0]  microsecond_rest,
	input logic [32:0] tai_seconds,
	input logic [19:0] tai_microsecond
);

	// a rejected time carries nothing but its status
	`UTD_ASSERT_IMP(a_bad_zero, clk, arst_n, out_valid && status == STATUS_BAD, day_number == 16'd0 && millisecond_of_day == 27'd0 && microsecond_rest == 10'd0 && tai_seconds == 33'd0 && tai_microsecond == 20'd0)

	// good results stay inside their ranges
	`UTD_ASSERT_IMP(a_ok_range, clk, arst_n, out_valid && status == STATUS_OK, microsecond_rest < 10'd1000 && tai_microsecond < 20'd1000000 && millisecond_of_day < 27'd86401000)

	// a stalled transaction holds
	`UTD_ASSERT_NXT(a_out_hold, clk, arst_n, out_valid && out_stall, out_valid && $stable(status) && $stable(tai_seconds) && $stable(millisecond_of_day))

endmodule

bind utc_to_tai_day_msec utd_port_checker u_port_checker (
	.clk                (clk),
	.arst_n             (arst_n),
	.out_valid          (out_valid),
	.out_stall          (out_stall),
	.status             (status),
	.day_number         (day_number),
	.millisecond_of_day (millisecond_of_day),
	.microsecond_rest   (microsecond_rest),
	.tai_seconds        (tai_seconds),
	.tai_microsecond    (tai_microsecond)
);

### tb/utc_to_tai_day_msec_tb.sv
module utc_to_tai_day_msec_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import utd_pkg::*;

	localparam int LEAP_ENTRIES = 24;
	// only the first LEAP_ENTRIES-1 table rows take part, never more than the built-in ones
	localparam int USED_LEAPS = (LEAP_ENTRIES - 1 < KNOWN_LEAPS) ? LEAP_ENTRIES - 1 : KNOWN_LEAPS;

	localparam int CYCLE_LIMIT = 300000;
	localparam int SETTLE_CYCLES = 8;
	// switch points of the idle pattern, counted in transactions
	localparam int MODE_B_AT = 420;
	localparam int MODE_C_AT = 840;
	// sender waits for the pipeline to drain at this count
	localparam int DRAIN_AT = 700;
	// receiver holds off for a long stretch at these counts
	localparam int HOLD_AT_A = 500;
	localparam int HOLD_AT_B = 1000;
	localparam int HOLD_LEN = 80;

	localparam int unsigned MONTH_DAYS [12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};
	localparam int unsigned MONTH_FIRST [12] =
		'{0, 31, 59, 90, 120, 151, 181, 212, 243, 273, 304, 334};

	// register settings, one column per phase; phase 0 keeps the reset values
	localparam int NUM_PHASES = 6;
	localparam int unsigned PH_FIRST_YEAR [NUM_PHASES] = '{1972, 1972, 2050, 1990, 1960, 1999};
	localparam int unsigned PH_FIRST_MONTH [NUM_PHASES] = '{0, 0, 11, 6, 3, 0};
	localparam int unsigned PH_END_YEAR [NUM_PHASES] = '{2020, 2099, 2099, 1992, 4095, 1972};
	localparam int unsigned PH_END_MONTH [NUM_PHASES] = '{0, 11, 11, 7, 12, 0};
	localparam int unsigned PH_EPOCH_DAYS [NUM_PHASES] = '{5113, 0, 16383, 5113, 100, 777};
	localparam int unsigned PH_RANDOM [NUM_PHASES] = '{250, 250, 250, 250, 150, 50};

	typedef struct packed {
		logic [11:0] year;
		logic [3:0]  month;
		logic [4:0]  day;
		logic [4:0]  hour;
		logic [5:0]  minute;
		logic [5:0]  second;
		logic [19:0] usec;
	} utc_stamp_t;

	typedef struct packed {
		logic        status;
		logic [15:0] day_number;
		logic [26:0] msec_of_day;
		logic [9:0]  usec_rest;
		logic [32:0] tai_sec;
		logic [19:0] tai_usec;
	} tai_result_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 cfg_write = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = REG_FIRST_YEAR;
	logic [CFG_W-1:0]     cfg_data = '0;
	logic                 in_valid = 1'b0;
	logic                 in_stall;
	utc_stamp_t           offered = '0;
	logic                 out_valid;
	logic                 out_stall = 1'b0;
	tai_result_t          seen;

	// register copy kept by the testbench, starts at the reset values
	cfg_t regs = '{first_year: 12'd1972, first_month: 4'd0, end_year: 12'd2020,
		end_month: 4'd0, epoch_day_offset: 14'd5113};

	utc_stamp_t  pending_stamps[$];
	tai_result_t due_results[$];
	int          stamps_sent = 0;
	int          results_seen = 0;
	int          mismatches = 0;
	int          holdoff_left = 0;
	int          cycles = 0;

	utc_to_tai_day_msec #(.LEAP_ENTRIES(LEAP_ENTRIES)) uut (
		.clk                (clk),
		.arst_n             (arst_n),
		.cfg_write          (cfg_write),
		.cfg_index          (cfg_index),
		.cfg_data           (cfg_data),
		.in_valid           (in_valid),
		.in_stall           (in_stall),
		.year_in            (offered.year),
		.month_index        (offered.month),
		.day_index          (offered.day),
		.hour_in            (offered.hour),
		.minute_in          (offered.minute),
		.second_in          (offered.second),
		.microsecond_in     (offered.usec),
		.out_valid          (out_valid),
		.out_stall          (out_stall),
		.status             (seen.status),
		.day_number         (seen.day_number),
		.millisecond_of_day (seen.msec_of_day),
		.microsecond_rest   (seen.usec_rest),
		.tai_seconds        (seen.tai_sec),
		.tai_microsecond    (seen.tai_usec)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// gregorian rule: every 4th year, except centuries not divisible by 400
	function automatic bit leap_year(input int unsigned y);
		if (y % 4 != 0) return 1'b0;
		if (y % 400 == 0) return 1'b1;
		return (y % 100 != 0);
	endfunction

	// leap years from year 1 up to and including y
	function automatic longint unsigned leaps_through(input int unsigned y);
		return y / 4 - y / 100 + y / 400;
	endfunction

	function automatic int unsigned days_in_month(input int unsigned y, input int unsigned m);
		return MONTH_DAYS[m] + ((m == 1 && leap_year(y)) ? 1 : 0);
	endfunction

	// expected output transaction for one input transaction under the given registers
	function automatic tai_result_t utc_to_tai(input utc_stamp_t t, input cfg_t c);
		tai_result_t r;
		logic [15:0] key;
		int unsigned mlen, idx, minute_len, ny, nm, py, pm;
		bit found;
		longint unsigned days, secs;
		r = '0;
		r.status = STATUS_BAD;
		if (t.month >= 12) return r;
		key = {t.year, t.month};
		if (key < {c.first_year, c.first_month}) return r;
		if (key >= {c.end_year, c.end_month}) return r;
		mlen = days_in_month(t.year, t.month);
		if (t.day >= mlen) return r;
		if (t.hour >= 24 || t.minute >= 60 || t.usec >= 1000000) return r;

		// latest table row at or before this month
		found = 1'b0;
		idx = 0;
		for (int i = 0; i < USED_LEAPS; i++) begin
			if (key >= LEAP_KEY[i]) begin
				idx = i;
				found = 1'b1;
			end
		end
		if (!found) return r;

		// last minute of the month before the next row is stretched by the offset step
		minute_len = 60;
		if (idx + 1 < USED_LEAPS && t.day == mlen - 1 && t.hour == 23 && t.minute == 59) begin
			ny = 32'(LEAP_KEY[idx + 1][15:4]);
			nm = 32'(LEAP_KEY[idx + 1][3:0]);
			py = (nm == 0) ? ny - 1 : ny;
			pm = (nm == 0) ? 11 : nm - 1;
			if (py == t.year && pm == t.month)
				minute_len += 32'(LEAP_DELTA[idx + 1]) - 32'(LEAP_DELTA[idx]);
		end
		if (t.second >= minute_len) return r;

		days = 64'(c.epoch_day_offset);
		if (t.year > 1972)
			days += 365 * (t.year - 1972) + leaps_through(t.year - 1) - leaps_through(1971);
		days += MONTH_FIRST[t.month] + ((leap_year(t.year) && t.month >= 2) ? 1 : 0);
		days = (days + t.day) & 64'hFFFF;
		secs = t.hour * 3600 + t.minute * 60 + t.second;

		r.status = STATUS_OK;
		r.day_number = days[15:0];
		r.msec_of_day = 27'(secs * 1000 + t.usec / 1000);
		r.usec_rest = 10'(t.usec % 1000);
		r.tai_sec = 33'(days * 86400 + secs + LEAP_DELTA[idx]);
		r.tai_usec = t.usec;
		return r;
	endfunction

	function automatic utc_stamp_t random_stamp();
		utc_stamp_t s;
		int unsigned pick, mlen, row;
		logic [15:0] k;
		pick = $urandom_range(99);

		// start from a well-formed time inside the month window
		for (int n = 0; n < 6; n++) begin
			if (regs.end_year >= regs.first_year)
				s.year = 12'($urandom_range(regs.end_year, regs.first_year));
			else
				s.year = 12'($urandom_range(4095));
			s.month = 4'($urandom_range(11));
			if ({s.year, s.month} >= {regs.first_year, regs.first_month} &&
				{s.year, s.month} < {regs.end_year, regs.end_month}) break;
		end
		mlen = days_in_month(s.year, s.month);
		s.day = 5'($urandom_range(mlen - 1));
		s.hour = 5'($urandom_range(23));
		s.minute = 6'($urandom_range(59));
		s.second = 6'($urandom_range(59));
		s.usec = 20'($urandom_range(999999));

		if (pick < 55) begin
			// sometimes the last minute of an ordinary month
			if ($urandom_range(9) == 0) begin
				s.day = 5'(mlen - 1);
				s.hour = 5'd23;
				s.minute = 6'd59;
				s.second = 6'($urandom_range(61, 58));
			end
		end else if (pick < 72) begin
			// last minute before a table row, or past the final row
			if ($urandom_range(6) == 0) begin
				s.year = 12'($urandom_range(2099, 1999));
				s.month = 4'($urandom_range(11));
			end else begin
				row = $urandom_range(KNOWN_LEAPS - 1);
				k = LEAP_KEY[row];
				if (k[3:0] == 4'd0) begin
					s.year = k[15:4] - 12'd1;
					s.month = 4'd11;
				end else begin
					s.year = k[15:4];
					s.month = k[3:0] - 4'd1;
				end
			end
			s.day = 5'(days_in_month(s.year, s.month) - 1);
			s.hour = 5'd23;
			s.minute = 6'd59;
			s.second = 6'($urandom_range(61, 58));
		end else if (pick < 87) begin
			// one field just out of range
			case ($urandom_range(5))
				0: s.day = 5'($urandom_range(31, mlen));
				1: s.hour = 5'($urandom_range(31, 24));
				2: s.minute = 6'($urandom_range(63, 60));
				3: s.second = 6'($urandom_range(63, 60));
				4: s.usec = 20'($urandom_range(1048575, 1000000));
				default: s.month = 4'($urandom_range(15, 12));
			endcase
		end else begin
			s.year = 12'($urandom_range(4095));
			s.month = 4'($urandom_range(15));
			s.day = 5'($urandom_range(31));
			s.hour = 5'($urandom_range(31));
			s.minute = 6'($urandom_range(63));
			s.second = 6'($urandom_range(63));
			s.usec = 20'($urandom_range(1048575));
		end
		return s;
	endfunction

	function automatic int sender_gap_pct(input int n);
		if (n < MODE_B_AT) return 35;
		if (n < MODE_C_AT) return 80;
		return 0;
	endfunction

	function automatic int receiver_gap_pct(input int n);
		if (n < MODE_B_AT) return 80;
		if (n < MODE_C_AT) return 35;
		return 0;
	endfunction

	task automatic add_stamp(input int unsigned y, mo, d, h, mi, sec, us);
		utc_stamp_t st;
		st.year = 12'(y);
		st.month = 4'(mo);
		st.day = 5'(d);
		st.hour = 5'(h);
		st.minute = 6'(mi);
		st.second = 6'(sec);
		st.usec = 20'(us);
		pending_stamps.push_back(st);
	endtask

	// a register takes its value at the edge after the one that drives it
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned val);
		@(posedge clk);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val[CFG_W-1:0];
		case (idx)
			REG_FIRST_YEAR:  regs.first_year = val[11:0];
			REG_FIRST_MONTH: regs.first_month = val[3:0];
			REG_END_YEAR:    regs.end_year = val[11:0];
			REG_END_MONTH:   regs.end_month = val[3:0];
			REG_EPOCH_DAYS:  regs.epoch_day_offset = val[13:0];
			default: ;
		endcase
	endtask

	// nothing queued, nothing on the bus, nothing still owed by the block
	task automatic wait_idle();
		@(negedge clk);
		while (pending_stamps.size() != 0 || in_valid || due_results.size() != 0)
			@(negedge clk);
	endtask

	task automatic queue_directed(input int p);
		case (p)
			0: begin
				add_stamp(1972, 0, 0, 0, 0, 0, 0);
				add_stamp(2019, 11, 30, 23, 59, 59, 999999);
				add_stamp(2020, 0, 0, 0, 0, 0, 0);            // first month past the window
				add_stamp(1971, 11, 30, 23, 59, 60, 0);       // just before the window
				add_stamp(1985, 12, 0, 0, 0, 0, 0);
				add_stamp(1985, 15, 0, 0, 0, 0, 0);
				add_stamp(1972, 5, 29, 23, 59, 60, 500000);   // leap second, june 1972
				add_stamp(1972, 5, 29, 23, 59, 61, 0);
				add_stamp(1972, 5, 28, 23, 59, 60, 0);        // not the last day
				add_stamp(1972, 5, 29, 23, 58, 60, 0);        // not the last minute
				add_stamp(1998, 11, 30, 23, 59, 60, 999999);  // minute before the final row
				add_stamp(2005, 11, 30, 23, 59, 60, 0);       // past the final row
				add_stamp(1999, 5, 29, 23, 59, 60, 0);
				add_stamp(2000, 1, 28, 12, 0, 0, 0);          // feb 29, divisible by 400
				add_stamp(1996, 1, 28, 0, 0, 0, 0);
				add_stamp(1999, 1, 28, 0, 0, 0, 0);
				add_stamp(1985, 0, 31, 0, 0, 0, 0);
				add_stamp(1985, 3, 30, 0, 0, 0, 0);
				add_stamp(1985, 0, 0, 24, 0, 0, 0);
				add_stamp(1985, 0, 0, 0, 60, 0, 0);
				add_stamp(1985, 0, 0, 0, 0, 63, 0);
				add_stamp(1985, 0, 0, 0, 0, 0, 1000000);
				add_stamp(1985, 0, 0, 31, 63, 63, 1048575);
				add_stamp(4095, 15, 31, 31, 63, 63, 1048575);
			end
			1: begin
				add_stamp(1972, 0, 0, 0, 0, 0, 0);
				add_stamp(2099, 11, 30, 23, 59, 59, 999999);
				add_stamp(2099, 11, 30, 23, 59, 60, 0);
			end
			2: begin
				add_stamp(2050, 10, 29, 0, 0, 0, 0);
				add_stamp(2050, 11, 0, 0, 0, 0, 0);
				add_stamp(2099, 10, 29, 23, 59, 59, 999999);  // largest day count in range
				add_stamp(2099, 11, 0, 0, 0, 0, 0);
			end
			3: begin
				add_stamp(1990, 5, 29, 23, 59, 59, 0);
				add_stamp(1990, 6, 0, 0, 0, 0, 0);
				add_stamp(1990, 11, 30, 23, 59, 60, 0);
				add_stamp(1992, 5, 29, 23, 59, 60, 0);
				add_stamp(1992, 6, 30, 0, 0, 0, 0);
				add_stamp(1992, 7, 0, 0, 0, 0, 0);
			end
			4: begin
				// window reaches before the table and far past the wrap of the day count
				add_stamp(1960, 2, 0, 0, 0, 0, 0);
				add_stamp(1960, 3, 0, 0, 0, 0, 0);
				add_stamp(1971, 11, 30, 23, 59, 60, 0);
				add_stamp(2100, 1, 28, 0, 0, 0, 0);           // century, not a leap year
				add_stamp(2100, 1, 27, 0, 0, 0, 0);
				add_stamp(4000, 1, 28, 23, 59, 59, 999999);
				add_stamp(4095, 11, 30, 23, 59, 59, 999999);
			end
			default: begin
				add_stamp(1985, 6, 0, 0, 0, 0, 0);
			end
		endcase
	endtask

	// driver: offers queued transactions, predicts each one as it is accepted
	always @(posedge clk or negedge arst_n) begin : feeder
		bit gap;
		if (!arst_n) begin
			in_valid <= 1'b0;
			offered <= '0;
		end else begin
			if (in_valid && !in_stall) begin
				due_results.push_back(utc_to_tai(offered, regs));
				stamps_sent++;
			end
			// a stalled transaction stays on the bus unchanged
			if (!(in_valid && in_stall)) begin
				gap = ($urandom_range(99) < sender_gap_pct(stamps_sent)) ||
					(stamps_sent == DRAIN_AT && due_results.size() != 0);
				if (pending_stamps.size() != 0 && !gap) begin
					offered <= pending_stamps.pop_front();
					in_valid <= 1'b1;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	task automatic check_field(input string what, input longint unsigned want, got);
		if (want != got) begin
			$display("%0t: %s mismatch, expected %0d, got %0d", $realtime, what, want, got);
			mismatches++;
		end
	endtask

	// monitor: compares each output transaction with the oldest prediction
	always @(posedge clk or negedge arst_n) begin : watcher
		tai_result_t want;
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			if (out_valid && !out_stall) begin
				if (due_results.size() == 0) begin
					$display("%0t: unexpected transaction, expected none, got %h", $realtime, seen);
					mismatches++;
				end else begin
					want = due_results.pop_front();
					check_field("status", want.status, seen.status);
					check_field("day_number", want.day_number, seen.day_number);
					check_field("millisecond_of_day", want.msec_of_day, seen.msec_of_day);
					check_field("microsecond_rest", want.usec_rest, seen.usec_rest);
					check_field("tai_seconds", want.tai_sec, seen.tai_sec);
					check_field("tai_microsecond", want.tai_usec, seen.tai_usec);
				end
				results_seen++;
				// long hold-off so the pipeline fills and pushes back on the sender
				if (results_seen == HOLD_AT_A || results_seen == HOLD_AT_B)
					holdoff_left = HOLD_LEN;
			end
			if (holdoff_left > 0) begin
				holdoff_left--;
				out_stall <= 1'b1;
			end else begin
				out_stall <= ($urandom_range(99) < receiver_gap_pct(results_seen));
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		for (int p = 0; p < NUM_PHASES; p++) begin
			wait_idle();
			// registers change only with the block empty
			if (p > 0) begin
				write_reg(REG_FIRST_YEAR, PH_FIRST_YEAR[p]);
				write_reg(REG_FIRST_MONTH, PH_FIRST_MONTH[p]);
				write_reg(REG_END_YEAR, PH_END_YEAR[p]);
				write_reg(REG_END_MONTH, PH_END_MONTH[p]);
				write_reg(REG_EPOCH_DAYS, PH_EPOCH_DAYS[p]);
				@(posedge clk);
				cfg_write <= 1'b0;
			end
			@(negedge clk);
			queue_directed(p);
			for (int n = 0; n < PH_RANDOM[p]; n++)
				pending_stamps.push_back(random_stamp());
		end
		wait_idle();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatches == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule
